>>> hw/rtl/toeq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package toeq_pkg;

  localparam int unsigned TagW  = 3;
  localparam int unsigned TimeW = 32;
  localparam int unsigned OccW  = 5;

  localparam logic KindInsert = 1'b0;
  localparam logic KindPop    = 1'b1;

  typedef struct packed {
    logic [TagW-1:0]  tag;
    logic [TimeW-1:0] trig_time;
  } entry_t;

  // operation broadcast to every cell in the same cycle
  typedef struct packed {
    logic   ins_en;
    logic   pop_en;
    entry_t new_entry;
  } cell_ctrl_t;

endpackage

`default_nettype wire

>>> hw/rtl/toeq_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module toeq_cell (
  input  wire logic                clk_i,
  input  wire toeq_pkg::cell_ctrl_t ctrl_i,
  input  wire logic                occ_i,
  input  wire logic                left_gt_i,
  input  wire toeq_pkg::entry_t    left_entry_i,
  input  wire toeq_pkg::entry_t    right_entry_i,
  output      toeq_pkg::entry_t    entry_o,
  output      logic                gt_o
);
  import toeq_pkg::*;

  entry_t entry_q, entry_d;

  assign gt_o = occ_i && (entry_q.trig_time > ctrl_i.new_entry.trig_time);

  always_comb begin
    entry_d = entry_q;
    priority if (ctrl_i.ins_en) begin
      priority if (left_gt_i) begin
        entry_d = left_entry_i;
      end else if (gt_o || !occ_i) begin
        entry_d = ctrl_i.new_entry;
      end else begin
        entry_d = entry_q;
      end
    end else if (ctrl_i.pop_en) begin
      entry_d = right_entry_i;
    end else begin
      entry_d = entry_q;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

`default_nettype wire

>>> hw/rtl/timestamp_ordered_event_queue_top.sv
// timestamp ordered event queue
// input channel s_axis: tuser carries the kind (0 insert, 1 pop), tdata the
// event tag and 16.16 trigger time. every input transfer gives exactly one
// result transfer on m_axis: pop_valid and overflow in tuser, popped tag,
// popped time and the occupancy after the item in tdata.
// entries sit in a row of QUEUE_DEPTH cells, earliest in cell 0. each cell
// compares its own time with the broadcast time and takes the new entry,
// its left neighbour's entry (insert shift) or its right neighbour's entry
// (pop shift), so all cells take an item in the same cycle whatever the occupancy.
// the result is valid in the cycle after the input transfer; one item per
// cycle is sustained while the receiver takes results.
// the result sits in an output register; a new item is accepted in the
// same cycle the waiting result is taken. if the receiver stalls, s_axis
// tready falls until the held result is transferred.
// reset empties the queue and drops any waiting result; no clearing pass.
// a pop on an empty queue returns pop_valid low with zero tag and time; an
// insert into a full queue is dropped with overflow high.
`timescale 1ns / 1ps
`default_nettype none

module timestamp_ordered_event_queue_top #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output      logic        s_axis_tready_o,
  input  wire logic [39:0] s_axis_tdata_i,   // event_tag, trigger_time, zero fill
  input  wire logic        s_axis_tuser_i,   // kind
  output      logic        m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output      logic [39:0] m_axis_tdata_o,   // popped_tag, popped_time, occupancy
  output      logic [1:0]  m_axis_tuser_o    // pop_valid, overflow
);
  import toeq_pkg::*;

  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  logic            in_xfer;
  logic            empty, full;
  cell_ctrl_t      ctrl;
  entry_t          cell_entry [QUEUE_DEPTH];
  logic            cell_gt    [QUEUE_DEPTH];
  logic            cell_occ   [QUEUE_DEPTH];
  logic [CntW-1:0] count_q, count_d;
  logic [CntW+OccW-1:0] count_ext;

  logic            out_valid_q;
  logic            pop_valid_q, pop_valid_d;
  logic            overflow_q, overflow_d;
  entry_t          popped_q, popped_d;
  logic [OccW-1:0] occ_q, occ_d;

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign in_xfer = s_axis_tvalid_i && s_axis_tready_o;

  assign empty = (count_q == '0);
  assign full  = (count_q == CntW'(QUEUE_DEPTH));

  always_comb begin
    ctrl.ins_en              = in_xfer && (s_axis_tuser_i == KindInsert) && !full;
    ctrl.pop_en              = in_xfer && (s_axis_tuser_i == KindPop) && !empty;
    ctrl.new_entry.tag       = s_axis_tdata_i[TagW-1:0];
    ctrl.new_entry.trig_time = s_axis_tdata_i[TagW+TimeW-1:TagW];
  end

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    entry_t left_entry, right_entry;
    logic   left_gt;

    assign cell_occ[i] = (count_q > CntW'(i));

    if (i == 0) begin : g_first
      assign left_entry = ctrl.new_entry;
      assign left_gt    = 1'b0;
    end else begin : g_mid
      assign left_entry = cell_entry[i-1];
      assign left_gt    = cell_gt[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign right_entry = cell_entry[i];
    end else begin : g_inner
      assign right_entry = cell_entry[i+1];
    end

    toeq_cell u_cell (
      .clk_i         (clk_i),
      .ctrl_i        (ctrl),
      .occ_i         (cell_occ[i]),
      .left_gt_i     (left_gt),
      .left_entry_i  (left_entry),
      .right_entry_i (right_entry),
      .entry_o       (cell_entry[i]),
      .gt_o          (cell_gt[i])
    );
  end

  always_comb begin
    count_d = count_q;
    if (ctrl.ins_en) begin
      count_d = count_q + CntW'(1);
    end else if (ctrl.pop_en) begin
      count_d = count_q - CntW'(1);
    end
  end

  assign count_ext   = {{OccW{1'b0}}, count_d};
  assign pop_valid_d = ctrl.pop_en;
  assign overflow_d  = in_xfer && (s_axis_tuser_i == KindInsert) && full;
  assign popped_d    = ctrl.pop_en ? cell_entry[0] : '0;
  assign occ_d       = count_ext[OccW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (in_xfer) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      pop_valid_q <= pop_valid_d;
      overflow_q  <= overflow_d;
      popped_q    <= popped_d;
      occ_q       <= occ_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = {overflow_q, pop_valid_q};
  assign m_axis_tdata_o  = {occ_q, popped_q.trig_time, popped_q.tag};

endmodule

`default_nettype wire

>>> hw/rtl/toeq_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module toeq_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid_i,
  input wire logic        s_axis_tready_o,
  input wire logic        m_axis_tvalid_o,
  input wire logic        m_axis_tready_i,
  input wire logic [39:0] m_axis_tdata_o,
  input wire logic [1:0]  m_axis_tuser_o
);

  // a result never reports both a popped entry and a dropped insert
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !(m_axis_tuser_o[0] && m_axis_tuser_o[1]))
    else $error("pop_valid and overflow both set");

  // no entry returned means tag and time are zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tuser_o[0]) |-> (m_axis_tdata_o[34:0] == 35'd0))
    else $error("popped fields not zero without pop_valid");

  // every input transfer produces a result in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> m_axis_tvalid_o)
    else $error("input transfer without result");

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=>
      (m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o)))
    else $error("stalled result changed");

endmodule

bind timestamp_ordered_event_queue_top toeq_checker u_toeq_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);

`default_nettype wire

>>> dv/timestamp_ordered_event_queue_top_test.sv
`timescale 1ns / 1ps

module timestamp_ordered_event_queue_top_test;
  import toeq_pkg::*;

  localparam int unsigned QueueDepth = 16;
  localparam int unsigned ItemTarget = 900;
  localparam int unsigned HoldCycles = 120;
  localparam int unsigned StallLimit = 1000;

  typedef struct packed {
    logic            pop_valid;
    logic [TagW-1:0] tag;
    logic [31:0]     ptime;
    logic            overflow;
    logic [OccW-1:0] occupancy;
  } result_t;

  typedef struct packed {
    logic            kind;
    logic [TagW-1:0] tag;
    logic [31:0]     t;
    logic            known;
    result_t         want;
  } row_t;

  // known results only where they are plain from the sequence
  localparam row_t DirectedRows [22] = '{
    '{KindPop,    3'd0, 32'h0000_0000, 1'b1, '{1'b0, 3'd0, 32'h0, 1'b0, 5'd0}},
    '{KindInsert, 3'd7, 32'hFFFF_FFFF, 1'b1, '{1'b0, 3'd0, 32'h0, 1'b0, 5'd1}},
    '{KindInsert, 3'd0, 32'h0000_0000, 1'b1, '{1'b0, 3'd0, 32'h0, 1'b0, 5'd2}},
    '{KindInsert, 3'd5, 32'h0001_0000, 1'b1, '{1'b0, 3'd0, 32'h0, 1'b0, 5'd3}},
    '{KindInsert, 3'd2, 32'h0001_0000, 1'b1, '{1'b0, 3'd0, 32'h0, 1'b0, 5'd4}},
    '{KindInsert, 3'd3, 32'h0000_8000, 1'b1, '{1'b0, 3'd0, 32'h0, 1'b0, 5'd5}},
    '{KindPop,    3'd0, 32'h0000_0000, 1'b1, '{1'b1, 3'd0, 32'h0, 1'b0, 5'd4}},
    '{KindPop,    3'd0, 32'h0000_0000, 1'b0, '0},
    '{KindPop,    3'd0, 32'h0000_0000, 1'b0, '0},
    '{KindPop,    3'd0, 32'h0000_0000, 1'b0, '0},
    '{KindPop,    3'd0, 32'h0000_0000, 1'b1, '{1'b1, 3'd7, 32'hFFFF_FFFF, 1'b0, 5'd0}},
    '{KindPop,    3'd7, 32'hFFFF_FFFF, 1'b1, '{1'b0, 3'd0, 32'h0, 1'b0, 5'd0}},
    '{KindInsert, 3'd1, 32'hAAAA_AAAA, 1'b0, '0},
    '{KindInsert, 3'd6, 32'h5555_5555, 1'b0, '0},
    '{KindInsert, 3'd4, 32'hFFFF_FFFF, 1'b0, '0},
    '{KindInsert, 3'd3, 32'hFFFF_FFFF, 1'b0, '0},
    '{KindInsert, 3'd7, 32'h0000_0000, 1'b0, '0},
    '{KindPop,    3'd0, 32'h0000_0000, 1'b0, '0},
    '{KindPop,    3'd0, 32'h0000_0000, 1'b0, '0},
    '{KindPop,    3'd0, 32'h0000_0000, 1'b0, '0},
    '{KindPop,    3'd0, 32'h0000_0000, 1'b0, '0},
    '{KindPop,    3'd0, 32'h0000_0000, 1'b0, '0}
  };

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  wire         s_axis_tready_o;
  logic [39:0] s_axis_tdata_i = '0;   // event_tag, trigger_time, zero fill
  logic        s_axis_tuser_i = 1'b0; // kind
  wire         m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  wire  [39:0] m_axis_tdata_o;        // popped_tag, popped_time, occupancy
  wire  [1:0]  m_axis_tuser_o;        // pop_valid, overflow

  entry_t  held_entries[$];
  result_t pending_results[$];
  int      mismatch_count = 0;
  int      item_count = 0;
  bit      tx_idle_en = 1'b1;
  bit      rx_idle_en = 1'b1;
  int      hold_req = 0;

  timestamp_ordered_event_queue_top #(
    .QUEUE_DEPTH(QueueDepth)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o)
  );

  initial begin
    forever begin
      #5 clk_i = ~clk_i;
    end
  end

  function automatic result_t sorted_queue_step(logic kind, logic [TagW-1:0] tag,
                                                logic [31:0] t);
    result_t r;
    int      slot;
    entry_t  e;
    r = '0;
    if (kind == KindInsert) begin
      if (held_entries.size() >= QueueDepth) begin
        r.overflow = 1'b1;
      end else begin
        // after every entry whose time is not later
        slot = held_entries.size();
        for (int i = 0; i < held_entries.size(); i++) begin
          if (held_entries[i].trig_time > t) begin
            slot = i;
            break;
          end
        end
        e.tag = tag;
        e.trig_time = t;
        held_entries.insert(slot, e);
      end
    end else if (held_entries.size() > 0) begin
      e = held_entries.pop_front();
      r.pop_valid = 1'b1;
      r.tag = e.tag;
      r.ptime = e.trig_time;
    end
    r.occupancy = OccW'(held_entries.size());
    return r;
  endfunction

  // mix of wide values and clustered times so equal times turn up often
  function automatic logic [31:0] rand_time();
    logic [31:0] t;
    case ($urandom_range(0, 3))
      0: t = $urandom;
      1: t = 32'($urandom_range(0, 3)) << 16;
      2: t = ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'h0000_0000;
      default: t = 32'h0001_0000 + 32'($urandom_range(0, 7));
    endcase
    return t;
  endfunction

  task automatic push_item(input logic kind, input logic [TagW-1:0] tag,
                           input logic [31:0] t, input logic known, input result_t want);
    result_t predicted;
    while (tx_idle_en && $urandom_range(0, 99) < 9) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i <= kind;
    s_axis_tdata_i <= {5'b0, t, tag};
    do @(posedge clk_i); while (!s_axis_tready_o);
    predicted = sorted_queue_step(kind, tag, t);
    pending_results.push_back(known ? want : predicted);
    item_count++;
  endtask

  task automatic push_random(input int insert_pct);
    logic kind;
    kind = ($urandom_range(0, 99) < insert_pct) ? KindInsert : KindPop;
    push_item(kind, TagW'($urandom_range(0, 7)), rand_time(), 1'b0, '0);
  endtask

  task automatic drain_wait();
    s_axis_tvalid_i <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      mismatch_count++;
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
    end
  endtask

  // result side
  initial begin
    int hold_seen;
    hold_seen = 0;
    forever begin
      @(posedge clk_i);
      if (hold_seen != hold_req) begin
        hold_seen = hold_req;
        m_axis_tready_i <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end else begin
        m_axis_tready_i <= !(rx_idle_en && $urandom_range(0, 99) < 9);
      end
    end
  end

  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected result transfer, actual tdata %0h tuser %0h",
                 $time, m_axis_tdata_o, m_axis_tuser_o);
      end else begin
        want = pending_results.pop_front();
        check_field("pop_valid", 32'(want.pop_valid), 32'(m_axis_tuser_o[0]));
        check_field("overflow", 32'(want.overflow), 32'(m_axis_tuser_o[1]));
        check_field("popped_tag", 32'(want.tag), 32'(m_axis_tdata_o[2:0]));
        check_field("popped_time", want.ptime, m_axis_tdata_o[34:3]);
        check_field("occupancy", 32'(want.occupancy), 32'(m_axis_tdata_o[39:35]));
      end
    end
  end

  initial begin
    int stall_cycles;
    stall_cycles = 0;
    while (stall_cycles < StallLimit) begin
      @(posedge clk_i);
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
    end
    $display("tb: failure");
    $finish;
  end

  initial begin
    int round;
    int mode;
    int n;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DirectedRows[i]) begin
      push_item(DirectedRows[i].kind, DirectedRows[i].tag, DirectedRows[i].t,
                DirectedRows[i].known, DirectedRows[i].want);
    end

    round = 0;
    while (item_count < ItemTarget) begin
      tx_idle_en = (round < 4 || round > 10);
      rx_idle_en = (round < 4 || round > 10);
      mode = (round == 0) ? 3 : $urandom_range(0, 5);
      case (mode)
        3: begin
          // fill past full from an idle block while results are held back
          drain_wait();
          hold_req++;
          n = QueueDepth + $urandom_range(2, 6);
          repeat (n) push_random(100);
          repeat (6) push_random(50);
        end
        4: begin
          // drain through empty
          n = QueueDepth + $urandom_range(2, 4);
          repeat (n) push_random(0);
        end
        5: begin
          repeat (10) begin
            push_random(100);
            push_random(0);
          end
        end
        default: begin
          n = $urandom_range(30, 70);
          repeat (30) push_random(n);
        end
      endcase
      round++;
    end

    s_axis_tvalid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> files.f
hw/rtl/toeq_pkg.sv
hw/rtl/toeq_cell.sv
hw/rtl/timestamp_ordered_event_queue_top.sv
hw/rtl/toeq_checker.sv
dv/timestamp_ordered_event_queue_top_test.sv
